FILE: sv/caller_id_message_parser_unit_macros.svh
// Assertion macros shared by the caller-ID parser modules.
`ifndef CALLER_ID_MESSAGE_PARSER_UNIT_MACROS_SVH
`define CALLER_ID_MESSAGE_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define CIDP_ASSERT(label, ck, rst, prop, msg) \
  label: assert property (@(posedge ck) disable iff (!(rst)) (prop)) else $error(msg);
// A condition that must be followed in the next cycle by a consequence.
`define CIDP_ASSERT_NEXT(label, ck, rst, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rst)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CIDP_ASSERT(label, ck, rst, prop, msg)
`define CIDP_ASSERT_NEXT(label, ck, rst, ante, cons, msg)
`endif

`endif

FILE: sv/cidp_pkg.sv
// Shared types, constants and character class functions of the caller-ID parser.
package cidp_pkg;

  localparam int MAX_FIELD_CHARS_DEF = 127;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam logic [2:0] KIND_DATE  = 3'd0;
  localparam logic [2:0] KIND_TIME  = 3'd1;
  localparam logic [2:0] KIND_NAME  = 3'd2;
  localparam logic [2:0] KIND_PHONE = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
  localparam logic [7:0] CHAR_ONE      = 8'h31;
  localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7e;
  localparam logic [7:0] CHAR_P        = 8'h50;
  localparam logic [7:0] CHAR_O        = 8'h4f;

  localparam logic [3:0] DATE_CHARS     = 4'd4;
  localparam logic [3:0] DATETIME_CHARS = 4'd8;

  typedef enum logic [2:0] {
    PH_SEEK_DIGIT = 3'd0,
    PH_DATETIME   = 3'd1,
    PH_SKIP_NAME  = 3'd2,
    PH_NAME       = 3'd3,
    PH_SKIP_PHONE = 3'd4,
    PH_PHONE      = 3'd5,
    PH_DONE       = 3'd6
  } phase_t;

  // One message byte handed from the front to the back.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       do_parse;
    logic       last;
    logic       bad_hex;
  } mid_entry_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       name_private;
    logic       name_unavailable;
    logic       phone_private;
    logic       phone_unavailable;
    logic       bad_hex;
    logic       done_res;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_DIGIT_LO) && (c <= CHAR_DIGIT_HI);
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return (c >= CHAR_PRINT_LO) && (c <= CHAR_PRINT_HI);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

endpackage

FILE: sv/caller_id_message_parser_unit.sv
// Caller-ID message parser: top level joining the front, the back and their queues.
// The parser takes one hex character per clock cycle whenever full is low and
// delivers one result per cycle while empty is low. Each character travels
// through the front (hex decode and byte pairing), a QUEUE_DEPTH-entry queue,
// the back phase machine and a QUEUE_DEPTH-entry result queue; a byte is
// registered in the first queue, and the back writes each result into the
// result queue, from which the out_ ports read, as long as that queue has room.
// The back handles one queued byte per cycle while the result queue has room,
// except that a final beat that carries a message byte stays at the head of
// the queue so that its byte is parsed first and its end record follows.
// Sustained throughput is therefore one character per cycle, bounded by the
// rate at which results are popped.
module caller_id_message_parser_unit #(
  parameter int MAX_FIELD_CHARS = cidp_pkg::MAX_FIELD_CHARS_DEF,
  parameter int QUEUE_DEPTH     = cidp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_hex_char,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_name_private,
  output logic       out_name_unavailable,
  output logic       out_phone_private,
  output logic       out_phone_unavailable,
  output logic       out_bad_hex,
  output logic       out_done_res
);

  localparam int MID_W = $bits(cidp_pkg::mid_entry_t);
  localparam int RES_W = $bits(cidp_pkg::result_t);

  logic                 in_accept;
  logic                 mid_push, mid_pop, mid_full, mid_empty;
  cidp_pkg::mid_entry_t mid_in, mid_out;
  logic [MID_W-1:0]     mid_out_bits;
  logic                 res_push, res_full;
  cidp_pkg::result_t    res_in, res_out;
  logic [RES_W-1:0]     res_out_bits;

  assign full      = mid_full;
  assign in_accept = push && !mid_full;

  cidp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_hex_char (in_hex_char),
    .in_last     (in_last),
    .mid_push    (mid_push),
    .mid_entry   (mid_in)
  );

  cidp_fifo #(
    .WIDTH (MID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_in),
    .pop   (mid_pop),
    .dout  (mid_out_bits),
    .full  (mid_full),
    .empty (mid_empty)
  );

  assign mid_out = cidp_pkg::mid_entry_t'(mid_out_bits);

  cidp_back #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (!mid_empty),
    .entry       (mid_out),
    .entry_pop   (mid_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res_in)
  );

  cidp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop),
    .dout  (res_out_bits),
    .full  (res_full),
    .empty (empty)
  );

  assign res_out               = cidp_pkg::result_t'(res_out_bits);
  assign out_kind              = res_out.kind;
  assign out_value             = res_out.value;
  assign out_name_private      = res_out.name_private;
  assign out_name_unavailable  = res_out.name_unavailable;
  assign out_phone_private     = res_out.phone_private;
  assign out_phone_unavailable = res_out.phone_unavailable;
  assign out_bad_hex           = res_out.bad_hex;
  assign out_done_res          = res_out.done_res;

endmodule

FILE: sv/cidp_fifo.sv
// Small register FIFO used between the front and the back and at the result side.
`include "caller_id_message_parser_unit_macros.svh"

module cidp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cidp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  `CIDP_ASSERT(fifo_no_overflow, clk, rst_n, !(push && full), "push into a full queue")
  `CIDP_ASSERT(fifo_count_in_range, clk, rst_n, count_r <= CW'(DEPTH), "queue count past depth")

endmodule

FILE: sv/cidp_front.sv
// Front part: hex decode, nibble pairing and the one-byte hold that drops the checksum.
`include "caller_id_message_parser_unit_macros.svh"

module cidp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  logic [7:0]           in_hex_char,
  input  logic                 in_last,
  output logic                 mid_push,
  output cidp_pkg::mid_entry_t mid_entry
);

  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic       nibble_held_r, nibble_held_nxt;
  logic [7:0] delayed_byte_r, delayed_byte_nxt;
  logic       delayed_valid_r, delayed_valid_nxt;
  logic       hex_error_r, hex_error_nxt;

  logic [3:0] nib;
  logic       bad;
  logic       have_byte;
  logic [7:0] new_byte;
  logic       release_byte;

  always_comb begin
    nib = 4'h0;
    bad = 1'b0;
    if (in_hex_char >= 8'h30 && in_hex_char <= 8'h39) begin
      nib = 4'(in_hex_char - 8'h30);
    end else if (in_hex_char >= 8'h41 && in_hex_char <= 8'h46) begin
      nib = 4'(in_hex_char - 8'h37);
    end else if (in_hex_char >= 8'h61 && in_hex_char <= 8'h66) begin
      nib = 4'(in_hex_char - 8'h57);
    end else begin
      bad = 1'b1;
    end
  end

  // A lone final character forms a byte by itself.
  assign have_byte    = nibble_held_r || in_last;
  assign new_byte     = nibble_held_r ? {high_nibble_r, nib} : {4'h0, nib};
  assign release_byte = have_byte && delayed_valid_r && (delayed_byte_r != 8'h00);

  always_comb begin
    mid_entry.char_byte = delayed_byte_r;
    mid_entry.do_parse  = release_byte;
    mid_entry.last      = in_last;
    mid_entry.bad_hex   = hex_error_r || bad;
    mid_push            = in_accept && (release_byte || in_last);

    high_nibble_nxt   = high_nibble_r;
    nibble_held_nxt   = nibble_held_r;
    delayed_byte_nxt  = delayed_byte_r;
    delayed_valid_nxt = delayed_valid_r;
    hex_error_nxt     = hex_error_r;
    if (in_accept) begin
      if (in_last) begin
        // The byte formed now is the checksum; the message state starts over.
        high_nibble_nxt   = 4'h0;
        nibble_held_nxt   = 1'b0;
        delayed_byte_nxt  = 8'h00;
        delayed_valid_nxt = 1'b0;
        hex_error_nxt     = 1'b0;
      end else begin
        hex_error_nxt = hex_error_r || bad;
        if (nibble_held_r) begin
          nibble_held_nxt   = 1'b0;
          delayed_byte_nxt  = new_byte;
          delayed_valid_nxt = 1'b1;
        end else begin
          high_nibble_nxt = nib;
          nibble_held_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_nibble_r   <= 4'h0;
      nibble_held_r   <= 1'b0;
      delayed_byte_r  <= 8'h00;
      delayed_valid_r <= 1'b0;
      hex_error_r     <= 1'b0;
    end else begin
      high_nibble_r   <= high_nibble_nxt;
      nibble_held_r   <= nibble_held_nxt;
      delayed_byte_r  <= delayed_byte_nxt;
      delayed_valid_r <= delayed_valid_nxt;
      hex_error_r     <= hex_error_nxt;
    end
  end

  `CIDP_ASSERT_NEXT(front_clears_on_last, clk, rst_n, in_accept && in_last, !nibble_held_r && !delayed_valid_r && !hex_error_r, "front state not cleared after the final beat")

endmodule

FILE: sv/cidp_back.sv
// Back part: the field phase machine that turns message bytes into result beats.
`include "caller_id_message_parser_unit_macros.svh"

module cidp_back #(
  parameter int MAX_FIELD_CHARS = cidp_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 entry_valid,
  input  cidp_pkg::mid_entry_t entry,
  output logic                 entry_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output cidp_pkg::result_t    res
);

  localparam int LW = $clog2(MAX_FIELD_CHARS + 1);

  cidp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       dt_cnt_r, dt_cnt_nxt;
  logic [LW-1:0]    name_len_r, name_len_nxt;
  logic [LW-1:0]    phone_len_r, phone_len_nxt;
  logic [7:0]       name_first_r, name_first_nxt;
  logic [7:0]       name_second_r, name_second_nxt;
  logic [7:0]       phone_first_r, phone_first_nxt;
  logic             char_done_r, char_done_nxt;

  always_comb begin
    cidp_pkg::phase_t ph;
    logic [3:0]       cnt;
    logic [7:0]       b;

    ph  = phase_r;
    cnt = dt_cnt_r;
    b   = entry.char_byte;

    phase_nxt       = phase_r;
    dt_cnt_nxt      = dt_cnt_r;
    name_len_nxt    = name_len_r;
    phone_len_nxt   = phone_len_r;
    name_first_nxt  = name_first_r;
    name_second_nxt = name_second_r;
    phone_first_nxt = phone_first_r;
    char_done_nxt   = char_done_r;
    entry_pop       = 1'b0;
    res_push        = 1'b0;
    res             = '0;

    if (entry_valid && !res_full) begin
      if (entry.do_parse && !char_done_r) begin
        // Skip phases fall into the phase that follows them on a matching byte.
        if (ph == cidp_pkg::PH_SEEK_DIGIT && cidp_pkg::is_digit(b)) begin
          ph  = cidp_pkg::PH_DATETIME;
          cnt = 4'd0;
        end
        if (ph == cidp_pkg::PH_SKIP_NAME && cidp_pkg::is_print(b)) begin
          ph = cidp_pkg::PH_NAME;
        end
        if (ph == cidp_pkg::PH_SKIP_PHONE && cidp_pkg::is_print(b)) begin
          ph = cidp_pkg::PH_PHONE;
        end
        phase_nxt = ph;
        res.value = b;
        unique case (ph)
          cidp_pkg::PH_SEEK_DIGIT, cidp_pkg::PH_SKIP_NAME,
          cidp_pkg::PH_SKIP_PHONE, cidp_pkg::PH_DONE: begin
          end
          cidp_pkg::PH_DATETIME: begin
            res_push   = 1'b1;
            res.kind   = (cnt < cidp_pkg::DATE_CHARS) ? cidp_pkg::KIND_DATE
                                                      : cidp_pkg::KIND_TIME;
            dt_cnt_nxt = cnt + 4'd1;
            if ((cnt + 4'd1) >= cidp_pkg::DATETIME_CHARS) begin
              phase_nxt = cidp_pkg::PH_SKIP_NAME;
            end
          end
          cidp_pkg::PH_NAME: begin
            if (!cidp_pkg::is_print(b)) begin
              phase_nxt = cidp_pkg::PH_SKIP_PHONE;
            end else if (name_len_r < LW'(MAX_FIELD_CHARS)) begin
              if (name_len_r == '0) begin
                name_first_nxt = b;
              end else if (name_len_r == LW'(1)) begin
                name_second_nxt = b;
              end
              name_len_nxt = name_len_r + 1'b1;
              res_push     = 1'b1;
              res.kind     = cidp_pkg::KIND_NAME;
            end
          end
          cidp_pkg::PH_PHONE: begin
            if (!cidp_pkg::is_print(b)) begin
              phase_nxt = cidp_pkg::PH_DONE;
            end else if ((cidp_pkg::is_digit(b) || b == cidp_pkg::CHAR_O ||
                          b == cidp_pkg::CHAR_P) &&
                         phone_len_r < LW'(MAX_FIELD_CHARS)) begin
              if (phone_len_r == '0) begin
                phone_first_nxt = b;
              end
              phone_len_nxt = phone_len_r + 1'b1;
              res_push      = 1'b1;
              res.kind      = cidp_pkg::KIND_PHONE;
            end
          end
          default: begin
            phase_nxt = cidp_pkg::PH_DONE;
          end
        endcase
        // A final beat stays at the head so that its end record follows.
        if (entry.last) begin
          char_done_nxt = 1'b1;
        end else begin
          entry_pop = 1'b1;
        end
      end else begin
        // Only a final beat reaches here; it carries the end record.
        res_push              = 1'b1;
        res.kind              = cidp_pkg::KIND_END;
        res.value             = 8'h00;
        res.name_private      = (name_first_r == cidp_pkg::CHAR_P) &&
                                !(cidp_pkg::is_alpha(name_second_r) ||
                                  cidp_pkg::is_digit(name_second_r));
        res.name_unavailable  = (name_first_r == cidp_pkg::CHAR_O) &&
                                !(cidp_pkg::is_alpha(name_second_r) ||
                                  (name_second_r >= cidp_pkg::CHAR_ONE &&
                                   name_second_r <= cidp_pkg::CHAR_DIGIT_HI));
        res.phone_private     = (phone_first_r == cidp_pkg::CHAR_P);
        res.phone_unavailable = (phone_first_r == cidp_pkg::CHAR_O);
        res.bad_hex           = entry.bad_hex;
        res.done_res          = 1'b1;
        entry_pop             = 1'b1;
        phase_nxt             = cidp_pkg::PH_SEEK_DIGIT;
        dt_cnt_nxt            = 4'd0;
        name_len_nxt          = '0;
        phone_len_nxt         = '0;
        name_first_nxt        = 8'h00;
        name_second_nxt       = 8'h00;
        phone_first_nxt       = 8'h00;
        char_done_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cidp_pkg::PH_SEEK_DIGIT;
      dt_cnt_r      <= 4'd0;
      name_len_r    <= '0;
      phone_len_r   <= '0;
      name_first_r  <= 8'h00;
      name_second_r <= 8'h00;
      phone_first_r <= 8'h00;
      char_done_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      dt_cnt_r      <= dt_cnt_nxt;
      name_len_r    <= name_len_nxt;
      phone_len_r   <= phone_len_nxt;
      name_first_r  <= name_first_nxt;
      name_second_r <= name_second_nxt;
      phone_first_r <= phone_first_nxt;
      char_done_r   <= char_done_nxt;
    end
  end

  `CIDP_ASSERT(end_only_on_last, clk, rst_n, !(res_push && res.done_res) || entry.last, "end record from a beat that is not final")
  `CIDP_ASSERT_NEXT(back_resets_after_end, clk, rst_n, res_push && res.done_res, phase_r == cidp_pkg::PH_SEEK_DIGIT && name_len_r == '0 && !char_done_r, "field state not cleared after the end record")

endmodule
